// File: hdl/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants for the telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] pos_t;

	localparam int unsigned MAX_RECORDS = 255;
	localparam int unsigned FRAME_BYTES = 13;
	localparam int unsigned LEN_W       = 11;

	// configuration register indexes
	localparam logic [1:0] REG_RECORD_COUNT = 2'd0;
	localparam logic [1:0] REG_START_BYTE   = 2'd1;
	localparam logic [1:0] REG_END_BYTE     = 2'd2;

	// byte positions within one item's run
	localparam pos_t POS_START  = 4'd0;
	localparam pos_t POS_RECORD = 4'd4;
	localparam pos_t POS_VAL_HI = 4'd10;
	localparam pos_t POS_XOR    = 4'd11;
	localparam pos_t POS_END    = 4'd12;

	localparam byte_t BYTE_MASK = 8'hFF;

endpackage

// File: hdl/telemetry_frame_builder.sv
// ----------------------------------------------------------------------------
// telemetry_frame_builder
// Turns tag records into a byte frame with header, checksum and end marker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one record per transaction:
//   tag_id, quality, sample_value. Output channel (out_valid/out_stall)
//   gives one frame byte per transaction with frame_end and run_last flags.
//   The first record of a frame is preceded by start byte, 16-bit
//   little-endian length and count byte; the last record is followed by the
//   XOR checksum and the end byte.
//   The first byte of a record goes from the record stage into the output
//   register; the record stage is loaded when the record is accepted.
//   One byte per cycle leaves the output register while out_stall is low;
//   a record gives 7 bytes, 11 when it opens a frame, 9 when it closes one,
//   13 when it does both. The next record is accepted in the cycle its
//   predecessor's last byte enters the output register.
//   The user must write configuration (wr_en/wr_index/wr_data) only while
//   idle; the block itself does not enforce this.
//   Reset clears the frame state and loads count 1, start 0x02, end 0x03.
//   A stalled receiver holds the output byte; the record stage then fills
//   and in_stall rises.
// ----------------------------------------------------------------------------
module telemetry_frame_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [7:0]         wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        tag_id,
	input  logic [7:0]         quality,
	input  logic signed [31:0] sample_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               frame_end,
	output logic               run_last
);

	tfb_pkg::byte_t record_count_q, start_byte_q, end_byte_q;
	tfb_pkg::byte_t record_index_q, running_xor_q;

	tfb_pkg::byte_t bytes_s1 [tfb_pkg::FRAME_BYTES];
	logic           valid_s1;
	logic           close_s1;
	tfb_pkg::pos_t  pos_q;

	tfb_pkg::byte_t bytes_d [tfb_pkg::FRAME_BYTES];
	tfb_pkg::byte_t cnt;
	logic [tfb_pkg::LEN_W-1:0] len;
	logic           hdr, close_d;
	tfb_pkg::byte_t xor_d;
	logic           accept, load, last_pos;

	// effective count
	always_comb begin
		cnt = record_count_q;
		if (cnt == 8'd0)
			cnt = 8'd1;
		if ({1'b0, cnt} > 9'(tfb_pkg::MAX_RECORDS))
			cnt = 8'(tfb_pkg::MAX_RECORDS);
	end

	always_comb begin
		hdr     = (record_index_q == 8'd0);
		len     = ({cnt, 3'b000} - {3'b000, cnt}) + 11'd1;
		close_d = ({1'b0, record_index_q} + 9'd1) >= {1'b0, cnt};
		bytes_d[0]  = start_byte_q;
		bytes_d[1]  = len[7:0];
		bytes_d[2]  = {5'b00000, len[10:8]};
		bytes_d[3]  = cnt;
		bytes_d[4]  = tag_id[7:0];
		bytes_d[5]  = tag_id[15:8];
		bytes_d[6]  = quality;
		bytes_d[7]  = sample_value[7:0];
		bytes_d[8]  = sample_value[15:8];
		bytes_d[9]  = sample_value[23:16];
		bytes_d[10] = sample_value[31:24];
		xor_d = hdr ? (bytes_d[1] ^ bytes_d[2] ^ bytes_d[3]) : running_xor_q;
		xor_d = xor_d ^ bytes_d[4] ^ bytes_d[5] ^ bytes_d[6] ^ bytes_d[7]
		      ^ bytes_d[8] ^ bytes_d[9] ^ bytes_d[10];
		bytes_d[11] = xor_d & tfb_pkg::BYTE_MASK;
		bytes_d[12] = end_byte_q;
	end

	always_comb begin
		last_pos = close_s1 ? (pos_q == tfb_pkg::POS_END) : (pos_q == tfb_pkg::POS_VAL_HI);
		load     = valid_s1 && (!out_valid || !out_stall);
		in_stall = valid_s1 && !(load && last_pos);
		accept   = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q <= 8'd1;
			start_byte_q   <= 8'd2;
			end_byte_q     <= 8'd3;
		end else if (wr_en) begin
			case (wr_index)
				tfb_pkg::REG_RECORD_COUNT: record_count_q <= wr_data;
				tfb_pkg::REG_START_BYTE:   start_byte_q   <= wr_data;
				tfb_pkg::REG_END_BYTE:     end_byte_q     <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_index_q <= 8'd0;
			running_xor_q  <= 8'd0;
			valid_s1       <= 1'b0;
			pos_q          <= tfb_pkg::POS_START;
			out_valid      <= 1'b0;
		end else begin
			if (accept) begin
				record_index_q <= close_d ? 8'd0 : record_index_q + 8'd1;
				running_xor_q  <= close_d ? 8'd0 : xor_d;
				valid_s1       <= 1'b1;
				pos_q          <= hdr ? tfb_pkg::POS_START : tfb_pkg::POS_RECORD;
			end else if (load) begin
				pos_q <= pos_q + 4'd1;
				if (last_pos)
					valid_s1 <= 1'b0;
			end
			if (load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_s1 <= bytes_d;
			close_s1 <= close_d;
		end
		if (load) begin
			out_byte  <= bytes_s1[pos_q];
			frame_end <= (pos_q == tfb_pkg::POS_END);
			run_last  <= last_pos;
		end
	end

endmodule

// File: hdl/tfb_checker.sv
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks for the telemetry frame builder.
// ----------------------------------------------------------------------------
module tfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       run_last
);

	// hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("output byte changed under stall");

	// end byte closes the run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame end without run last");

	// a record never follows in the next cycle
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// bytes of one run come without gaps
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside a run");

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.frame_end (frame_end),
	.run_last  (run_last)
);

// File: dv/telemetry_frame_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_builder_tb
// Self-checking bench: tag records go in, each frame byte is checked against
// a local frame predictor. Directed frames cover field extremes, marker bytes,
// zero count, unused register index and count changes inside an open frame;
// random phases follow under random gaps and backpressure.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_tb;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  qual;
		logic [31:0] value;
	} tag_record_t;

	typedef struct packed {
		tfb_pkg::byte_t value;
		logic           at_end;
		logic           run_end;
	} frame_byte_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [7:0]  wr_data;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] tag_id = '0;
	logic [7:0]  quality = '0;
	logic [31:0] sample_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        run_last;

	tag_record_t records_to_send[$];
	frame_byte_t due_bytes[$];

	tfb_pkg::byte_t count_reg;
	tfb_pkg::byte_t start_reg;
	tfb_pkg::byte_t end_reg;
	tfb_pkg::byte_t rec_index;
	tfb_pkg::byte_t frame_xor;

	int          errors = 0;
	int unsigned cycle_count = 0;
	int          send_wait = 0;
	int          recv_wait = 0;
	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;
	tag_record_t next_rec;
	frame_byte_t got;

	telemetry_frame_builder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.tag_id       (tag_id),
		.quality      (quality),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_byte(input tfb_pkg::byte_t b, input logic at_end,
			input logic run_end, input logic summed);
		if (summed)
			frame_xor = frame_xor ^ b;
		due_bytes.push_back('{value: b, at_end: at_end, run_end: run_end});
	endtask

	task automatic frame_record(input tag_record_t r);
		logic [15:0]    len;
		tfb_pkg::byte_t eff;
		logic           closes;
		eff = (count_reg == 8'd0) ? 8'd1 : count_reg;
		closes = ({1'b0, rec_index} + 9'd1) >= {1'b0, eff};
		if (rec_index == 8'd0) begin
			len = 16'd1 + 16'd7 * {8'd0, eff};
			frame_xor = 8'd0;
			push_byte(start_reg, 1'b0, 1'b0, 1'b0);
			push_byte(len[7:0], 1'b0, 1'b0, 1'b1);
			push_byte(len[15:8], 1'b0, 1'b0, 1'b1);
			push_byte(eff, 1'b0, 1'b0, 1'b1);
		end
		push_byte(r.id[7:0], 1'b0, 1'b0, 1'b1);
		push_byte(r.id[15:8], 1'b0, 1'b0, 1'b1);
		push_byte(r.qual, 1'b0, 1'b0, 1'b1);
		push_byte(r.value[7:0], 1'b0, 1'b0, 1'b1);
		push_byte(r.value[15:8], 1'b0, 1'b0, 1'b1);
		push_byte(r.value[23:16], 1'b0, 1'b0, 1'b1);
		push_byte(r.value[31:24], 1'b0, !closes, 1'b1);
		if (closes) begin
			push_byte(frame_xor, 1'b0, 1'b0, 1'b0);
			push_byte(end_reg, 1'b1, 1'b1, 1'b0);
			rec_index = 8'd0;
			frame_xor = 8'd0;
		end else begin
			rec_index = rec_index + 8'd1;
		end
	endtask

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 7);
	endfunction

	// driver: hold the payload until the transaction completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				frame_record('{id: tag_id, qual: quality, value: sample_value});
				if ($urandom_range(0, 15) == 0)
					send_burst = !send_burst;
				send_wait = draw_gap(send_burst);
			end
			if (!in_valid || !in_stall) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (records_to_send.size() > 0) begin
					next_rec = records_to_send.pop_front();
					in_valid <= 1'b1;
					tag_id <= next_rec.id;
					quality <= next_rec.qual;
					sample_value <= next_rec.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each byte transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_bytes.size() == 0) begin
					$error("out_byte: expected none, got %h", out_byte);
					errors++;
				end else begin
					got = due_bytes.pop_front();
					if (out_byte !== got.value) begin
						$error("out_byte: expected %h, got %h", got.value, out_byte);
						errors++;
					end
					if (frame_end !== got.at_end) begin
						$error("frame_end: expected %b, got %b", got.at_end, frame_end);
						errors++;
					end
					if (run_last !== got.run_end) begin
						$error("run_last: expected %b, got %b", got.run_end, run_last);
						errors++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					recv_burst = !recv_burst;
				recv_wait = draw_gap(recv_burst);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input tfb_pkg::byte_t val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			tfb_pkg::REG_RECORD_COUNT: count_reg = val;
			tfb_pkg::REG_START_BYTE:   start_reg = val;
			tfb_pkg::REG_END_BYTE:     end_reg = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (records_to_send.size() != 0 || in_valid || due_bytes.size() != 0);
	endtask

	function automatic tag_record_t make_record();
		tag_record_t r;
		r.id = 16'($urandom);
		r.qual = 8'($urandom);
		r.value = $urandom;
		case ($urandom_range(0, 7))
			0: r.id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: r.qual = $urandom_range(0, 1) ? 8'hC0 : 8'h00;
			2: r.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_random(input int n);
		repeat (n) records_to_send.push_back(make_record());
		wait_for_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = tfb_pkg::REG_RECORD_COUNT;
		wr_data = 8'd0;
		count_reg = 8'd1;
		start_reg = 8'h02;
		end_reg = 8'h03;
		rec_index = 8'd0;
		frame_xor = 8'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, field extremes
		records_to_send.push_back('{16'h0000, 8'h00, 32'h0000_0000});
		records_to_send.push_back('{16'hFFFF, 8'hFF, 32'hFFFF_FFFF});
		records_to_send.push_back('{16'h1234, 8'hC0, 32'h8000_0000});
		records_to_send.push_back('{16'hABCD, 8'h00, 32'h7FFF_FFFF});
		wait_for_drain();

		// unused register index must leave settings alone
		write_reg(REG_NONE, 8'h55);
		records_to_send.push_back('{16'h00FF, 8'hC0, 32'h0102_0304});
		wait_for_drain();

		// zero count acts as one
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd0);
		write_reg(tfb_pkg::REG_START_BYTE, 8'h00);
		write_reg(tfb_pkg::REG_END_BYTE, 8'hFF);
		send_random(2);

		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd3);
		write_reg(tfb_pkg::REG_START_BYTE, 8'hFF);
		write_reg(tfb_pkg::REG_END_BYTE, 8'h00);
		send_random(3);

		// lower the count inside an open frame
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd5);
		send_random(2);
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd2);
		send_random(1);

		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd4);
		send_random(1);
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd1);
		send_random(1);

		// raise the count inside an open frame
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd2);
		send_random(1);
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd3);
		send_random(2);

		// random phases
		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd2);
		write_reg(tfb_pkg::REG_START_BYTE, 8'($urandom_range(0, 255)));
		write_reg(tfb_pkg::REG_END_BYTE, 8'($urandom_range(0, 255)));
		send_random(40);

		write_reg(tfb_pkg::REG_RECORD_COUNT, 8'd255);
		write_reg(tfb_pkg::REG_START_BYTE, 8'hFF);
		write_reg(tfb_pkg::REG_END_BYTE, 8'h00);
		send_random(260);

		repeat (6) begin
			write_reg(tfb_pkg::REG_RECORD_COUNT, 8'($urandom_range(0, 12)));
			write_reg(tfb_pkg::REG_START_BYTE, 8'($urandom_range(0, 255)));
			write_reg(tfb_pkg::REG_END_BYTE, 8'($urandom_range(0, 255)));
			send_random($urandom_range(15, 35));
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && due_bytes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hdl/tfb_pkg.sv
hdl/telemetry_frame_builder.sv
hdl/tfb_checker.sv
dv/telemetry_frame_builder_tb.sv
